// File: hdl/text_glyph_screen_placer_defines.svh
// Assertion macros for the glyph placer modules; only the queue module uses them.
`ifndef TEXT_GLYPH_SCREEN_PLACER_DEFINES_SVH
`define TEXT_GLYPH_SCREEN_PLACER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge out of reset
`define TGSP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tgsp: assertion failed");

// condition must never be seen out of reset
`define TGSP_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("tgsp: forbidden condition");

`else

`define TGSP_ASSERT(lbl, prop)
`define TGSP_ASSERT_NEVER(lbl, cond)

`endif

`endif

// File: hdl/tgsp_pkg.sv
// Types, widths and codes shared by the glyph placer modules.
package tgsp_pkg;

    localparam int COUNT_BITS = 16;             // line / column counter width, 8..24

    localparam logic [7:0] NL_CODE = 8'd10;
    localparam logic [7:0] SP_CODE = 8'd32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // queue between front and back; depth must be a power of two
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // datapath widths
    localparam int PX_W = ((COUNT_BITS + 8 > 24) ? COUNT_BITS + 8 : 24) + 1; // base + count<<8
    localparam int PR_W = PX_W + 16;            // times zoom
    localparam int ZX_W = PR_W - 12;            // floor shift by 12
    localparam int D_W  = ZX_W + 1;             // minus pivot
    localparam int P2_W = D_W + 16;             // times cos / sin
    localparam int R_W  = P2_W + 2;             // three-term sum
    localparam int Q_W  = R_W - 22;             // integer part

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_X  = 3'd0,
        CFG_BASE_Y  = 3'd1,
        CFG_ZOOM_X  = 3'd2,
        CFG_ZOOM_Y  = 3'd3,
        CFG_COS_ROT = 3'd4,
        CFG_SIN_ROT = 3'd5,
        CFG_PIVOT_X = 3'd6,
        CFG_PIVOT_Y = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [23:0] base_x;
        logic signed [23:0] base_y;
        logic signed [15:0] zoom_x;
        logic signed [15:0] zoom_y;
        logic signed [15:0] cos_rot;
        logic signed [15:0] sin_rot;
        logic signed [23:0] pivot_x;
        logic signed [23:0] pivot_y;
    } cfg_t;

    // one drawable glyph waiting for placement
    typedef struct packed {
        logic [COUNT_BITS-1:0] col;
        logic [COUNT_BITS-1:0] line;
        logic [7:0]            glyph;
    } cell_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

// File: hdl/text_glyph_screen_placer.sv
// Top level of the text glyph screen placer: config registers, front, queue, back.
//
//  channel  dir  handshake             payload
//  -------  ---  --------------------  ---------------------------------------------
//  s_*      in   s_tvalid / s_tready   tdata: char_code; tuser: text_start, erase_mode
//  m_*      out  m_tvalid / m_tready   tdata: screen_col, screen_row, glyph
//  cfg_*    in   cfg_valid / cfg_ready cfg_index selects register, cfg_data value
//
// Takes one character per cycle while the queue has room; the counters are
// the only state carried between items and update in the accept cycle.
// A drawn glyph is written into the 4-entry queue, leaves it into stage 0
// and then goes through the rest of the six-stage zoom/rotate pipeline to
// m_tdata; newline and space give no item.
// Output stalls fill the pipeline, then the queue, then drop s_tready.
// Async reset clears counters, queue and valids; config regs take their
// reset values (zoom 1.0, cos 1.0, rest zero). No clearing pass.
module text_glyph_screen_placer
    import tgsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input characters
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] char_code
    input  logic [1:0]            s_tuser,    // [0] text_start, [1] erase_mode
    // placed cells
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,    // [15:0] screen_col, [31:16] screen_row,
                                              // [39:32] glyph
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    q_stat_t q_stat;
    cell_t   push_cell, head_cell;
    logic    push, pop;

    // registers are always writable; writes must only come while idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BASE_X:  cfg_next.base_x  = cfg_data;
                CFG_BASE_Y:  cfg_next.base_y  = cfg_data;
                CFG_ZOOM_X:  cfg_next.zoom_x  = cfg_data[15:0];
                CFG_ZOOM_Y:  cfg_next.zoom_y  = cfg_data[15:0];
                CFG_COS_ROT: cfg_next.cos_rot = cfg_data[15:0];
                CFG_SIN_ROT: cfg_next.sin_rot = cfg_data[15:0];
                CFG_PIVOT_X: cfg_next.pivot_x = cfg_data;
                CFG_PIVOT_Y: cfg_next.pivot_y = cfg_data;
                default:     cfg_next         = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_x  <= '0;
            cfg_reg.base_y  <= '0;
            cfg_reg.zoom_x  <= 16'sd4096;     // 1.0 in Q3.12
            cfg_reg.zoom_y  <= 16'sd4096;
            cfg_reg.cos_rot <= 16'sd16384;    // 1.0 in Q1.14
            cfg_reg.sin_rot <= '0;
            cfg_reg.pivot_x <= '0;
            cfg_reg.pivot_y <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tgsp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .char_code  (s_tdata),
        .text_start (s_tuser[0]),
        .erase_mode (s_tuser[1]),
        .q_stat     (q_stat),
        .push       (push),
        .push_cell  (push_cell)
    );

    tgsp_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cell (push_cell),
        .pop       (pop),
        .head_cell (head_cell),
        .q_stat    (q_stat)
    );

    tgsp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .head_cell (head_cell),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: hdl/tgsp_front.sv
// Front end: takes characters, keeps line/column, queues drawable glyphs.
module tgsp_front
    import tgsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] char_code,
    input  logic       text_start,
    input  logic       erase_mode,
    input  q_stat_t    q_stat,
    output logic       push,
    output cell_t      push_cell
);

    logic [COUNT_BITS-1:0] col_reg,  col_next;
    logic [COUNT_BITS-1:0] line_reg, line_next;
    logic [COUNT_BITS-1:0] col_cur, line_cur;
    logic                  acc;

    always_comb
    begin
        s_tready = !q_stat.full;
        acc      = s_tvalid && s_tready;
        col_cur  = text_start ? '0 : col_reg;
        line_cur = text_start ? '0 : line_reg;

        col_next  = col_reg;
        line_next = line_reg;
        if (acc)
        begin
            if (char_code == NL_CODE)
            begin
                line_next = line_cur + COUNT_BITS'(1);
                col_next  = '0;
            end
            else
            begin
                // spaces and glyphs both advance one column
                line_next = line_cur;
                col_next  = col_cur + COUNT_BITS'(1);
            end
        end

        push            = acc && (char_code != NL_CODE) && (char_code != SP_CODE);
        push_cell.col   = col_cur;
        push_cell.line  = line_cur;
        push_cell.glyph = erase_mode ? SP_CODE : char_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            line_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

// File: hdl/tgsp_fifo.sv
// Short queue of pending cells between front and back.
`include "text_glyph_screen_placer_defines.svh"

module tgsp_fifo
    import tgsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cell_t   push_cell,
    input  logic    pop,
    output cell_t   head_cell,
    output q_stat_t q_stat
);

    cell_t             mem_reg [QDEPTH];
    logic [QA_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QA_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg,    cnt_next;

    always_comb
    begin
        q_stat.empty = (cnt_reg == '0);
        q_stat.full  = (cnt_reg == QCNT_W'(QDEPTH));
        head_cell    = mem_reg[rd_ptr_reg];

        wr_ptr_next = push ? wr_ptr_reg + QA_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QA_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (pop && !push)
            cnt_next = cnt_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `TGSP_ASSERT_NEVER(a_q_overflow, push && q_stat.full && !pop)
    `TGSP_ASSERT_NEVER(a_q_underflow, pop && q_stat.empty)
    `TGSP_ASSERT(a_q_count_up, (push && !pop) |=> (cnt_reg == $past(cnt_reg) + QCNT_W'(1)))
    `TGSP_ASSERT(a_q_ptr_gap, (QA_W'(wr_ptr_reg - rd_ptr_reg) == QA_W'(cnt_reg)))

endmodule

// File: hdl/tgsp_back.sv
// Back end: zoom, rotate, truncate and saturate, six register stages.
module tgsp_back
    import tgsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  q_stat_t     q_stat,
    input  cell_t       head_cell,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata
);

    localparam int NSTG = 6;

    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG-1:0] adv;

    logic [7:0] g_reg [NSTG];

    // stage 0: base + count
    logic signed [PX_W-1:0] px_reg, py_reg, px_next, py_next;
    // stage 1: times zoom
    logic signed [PR_W-1:0] zpx_reg, zpy_reg;
    // stage 2: floor, minus pivot
    logic signed [ZX_W-1:0] zx, zy;
    logic signed [D_W-1:0]  dx_reg, dy_reg, dx_next, dy_next;
    // stage 3: rotation products
    logic signed [P2_W-1:0] xc_reg, ys_reg, xs_reg, yc_reg;
    // stage 4: sums
    logic signed [R_W-1:0]  rx_reg, ry_reg, rx_next, ry_next;
    // stage 5: output
    logic [15:0] col_reg, row_reg;

    function automatic logic [15:0] trunc_sat(input logic signed [R_W-1:0] r);
        logic signed [Q_W-1:0] q;
        begin
            q = r[R_W-1:22];
            if (r[R_W-1] && (r[21:0] != '0))
                q = q + Q_W'(1);               // toward zero for negatives
            if (q > $signed(Q_W'(32767)))
                trunc_sat = 16'h7FFF;
            else if (q < -$signed(Q_W'(32768)))
                trunc_sat = 16'h8000;
            else
                trunc_sat = q[15:0];
        end
    endfunction

    always_comb
    begin
        adv[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];

        pop         = adv[0] && !q_stat.empty;
        vld_next[0] = adv[0] ? !q_stat.empty : vld_reg[0];
        for (int k = 1; k < NSTG; k++)
            vld_next[k] = adv[k] ? vld_reg[k-1] : vld_reg[k];

        px_next = $signed({{(PX_W-24){cfg.base_x[23]}}, cfg.base_x})
                + $signed({{(PX_W-COUNT_BITS-8){1'b0}}, head_cell.col, 8'h00});
        py_next = $signed({{(PX_W-24){cfg.base_y[23]}}, cfg.base_y})
                + $signed({{(PX_W-COUNT_BITS-8){1'b0}}, head_cell.line, 8'h00});

        zx      = zpx_reg[PR_W-1:12];
        zy      = zpy_reg[PR_W-1:12];
        dx_next = $signed({zx[ZX_W-1], zx})
                - $signed({{(D_W-24){cfg.pivot_x[23]}}, cfg.pivot_x});
        dy_next = $signed({zy[ZX_W-1], zy})
                - $signed({{(D_W-24){cfg.pivot_y[23]}}, cfg.pivot_y});

        rx_next = $signed({{2{xc_reg[P2_W-1]}}, xc_reg})
                - $signed({{2{ys_reg[P2_W-1]}}, ys_reg})
                + $signed({{(R_W-38){cfg.pivot_x[23]}}, cfg.pivot_x, 14'd0});
        ry_next = $signed({{2{xs_reg[P2_W-1]}}, xs_reg})
                + $signed({{2{yc_reg[P2_W-1]}}, yc_reg})
                + $signed({{(R_W-38){cfg.pivot_y[23]}}, cfg.pivot_y, 14'd0});

        m_tvalid = vld_reg[NSTG-1];
        m_tdata  = {g_reg[NSTG-1], row_reg, col_reg};
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            px_reg   <= px_next;
            py_reg   <= py_next;
            g_reg[0] <= head_cell.glyph;
        end
        if (adv[1])
        begin
            zpx_reg <= px_reg * cfg.zoom_x;
            zpy_reg <= py_reg * cfg.zoom_y;
        end
        if (adv[2])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (adv[3])
        begin
            xc_reg <= dx_reg * cfg.cos_rot;
            ys_reg <= dy_reg * cfg.sin_rot;
            xs_reg <= dx_reg * cfg.sin_rot;
            yc_reg <= dy_reg * cfg.cos_rot;
        end
        if (adv[4])
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
        if (adv[5])
        begin
            col_reg <= trunc_sat(rx_reg);
            row_reg <= trunc_sat(ry_reg);
        end
        for (int k = 1; k < NSTG; k++)
        begin
            if (adv[k])
                g_reg[k] <= g_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

endmodule

// File: tb/tgsp_cell_checker.sv
// Scoreboard for the glyph placer: predicts placed cells and compares the output stream.
`timescale 1ns / 100ps

module tgsp_cell_checker
    import tgsp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] char_code
    input  logic [1:0]            s_tuser,    // [0] text_start, [1] erase_mode
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [39:0]           m_tdata,    // [15:0] screen_col, [31:16] screen_row,
                                              // [39:32] glyph
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    cells_outstanding
);

    typedef struct packed {
        logic signed [15:0] col;
        logic signed [15:0] row;
        logic [7:0]         glyph;
    } screen_cell_t;

    cfg_t                  regs;
    logic [COUNT_BITS-1:0] line_no;
    logic [COUNT_BITS-1:0] col_no;
    screen_cell_t          cells_due [$];
    int                    misses;

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return 16'(v);
    endfunction

    // zoom per axis (floor), rotate about the pivot, truncate toward zero, saturate to 16 bits
    function automatic screen_cell_t place_cell(cfg_t r, logic [COUNT_BITS-1:0] col,
                                                logic [COUNT_BITS-1:0] line,
                                                logic [7:0] glyph);
        longint px, py, zx, zy, dx, dy, rx, ry, pvx, pvy, cs, sn;
        screen_cell_t c;
        pvx = longint'($signed(r.pivot_x));
        pvy = longint'($signed(r.pivot_y));
        cs  = longint'($signed(r.cos_rot));
        sn  = longint'($signed(r.sin_rot));
        px  = longint'($signed(r.base_x)) + (longint'(col) << 8);
        py  = longint'($signed(r.base_y)) + (longint'(line) << 8);
        zx  = (px * longint'($signed(r.zoom_x))) >>> 12;
        zy  = (py * longint'($signed(r.zoom_y))) >>> 12;
        dx  = zx - pvx;
        dy  = zy - pvy;
        rx  = dx * cs - dy * sn + pvx * 16384;
        ry  = dx * sn + dy * cs + pvy * 16384;
        c.col   = clamp16(rx / 4194304);
        c.row   = clamp16(ry / 4194304);
        c.glyph = glyph;
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        screen_cell_t got;
        screen_cell_t want;
        if (!rst_n)
        begin
            regs.base_x  = '0;
            regs.base_y  = '0;
            regs.zoom_x  = 16'sd4096;
            regs.zoom_y  = 16'sd4096;
            regs.cos_rot = 16'sd16384;
            regs.sin_rot = '0;
            regs.pivot_x = '0;
            regs.pivot_y = '0;
            line_no = '0;
            col_no  = '0;
            cells_due.delete();
            misses = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_BASE_X:  regs.base_x  = cfg_data;
                    CFG_BASE_Y:  regs.base_y  = cfg_data;
                    CFG_ZOOM_X:  regs.zoom_x  = cfg_data[15:0];
                    CFG_ZOOM_Y:  regs.zoom_y  = cfg_data[15:0];
                    CFG_COS_ROT: regs.cos_rot = cfg_data[15:0];
                    CFG_SIN_ROT: regs.sin_rot = cfg_data[15:0];
                    CFG_PIVOT_X: regs.pivot_x = cfg_data;
                    CFG_PIVOT_Y: regs.pivot_y = cfg_data;
                    default:     ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got.col   = m_tdata[15:0];
                got.row   = m_tdata[31:16];
                got.glyph = m_tdata[39:32];
                if (cells_due.size() == 0)
                begin
                    misses++;
                    if (misses <= 10)
                        $display("%0t: cell with none due: col %0d row %0d glyph %02h",
                                 $time, got.col, got.row, got.glyph);
                end
                else
                begin
                    want = cells_due.pop_front();
                    if (got.col !== want.col || got.row !== want.row ||
                        got.glyph !== want.glyph)
                    begin
                        misses++;
                        if (misses <= 10)
                            $display({"%0t: cell mismatch: expected col %0d row %0d glyph %02h,",
                                      " got col %0d row %0d glyph %02h"}, $time,
                                     want.col, want.row, want.glyph,
                                     got.col, got.row, got.glyph);
                    end
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0])
                begin
                    line_no = '0;
                    col_no  = '0;
                end
                if (s_tdata == NL_CODE)
                begin
                    line_no = line_no + 1'b1;
                    col_no  = '0;
                end
                else if (s_tdata == SP_CODE)
                    col_no = col_no + 1'b1;
                else
                begin
                    cells_due.push_back(place_cell(regs, col_no, line_no,
                                                   s_tuser[1] ? SP_CODE : s_tdata));
                    col_no = col_no + 1'b1;
                end
            end
        end
        fail_count        <= misses;
        cells_outstanding <= cells_due.size();
    end

endmodule

// File: tb/tb_text_glyph_screen_placer.sv
// Testbench top for the glyph placer: clock, reset, stimulus, output backpressure, verdict.
`timescale 1ns / 100ps

module tb_text_glyph_screen_placer;
    import tgsp_pkg::*;

    // drawn glyphs pass through the queue and the pipeline; allow a margin
    localparam int DRAIN_CYCLES = 12;

    typedef enum {SET_PLAIN, SET_ROTATED, SET_TOP, SET_BOTTOM, SET_WILD} setting_kind_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic [7:0]            s_tdata   = '0;    // [7:0] char_code
    logic [1:0]            s_tuser   = '0;    // [0] text_start, [1] erase_mode
    logic                  m_tready  = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    wire                   s_tready;
    wire                   m_tvalid;
    wire  [39:0]           m_tdata;            // [15:0] screen_col, [31:16] screen_row,
                                               // [39:32] glyph
    wire                   cfg_ready;
    int                    fail_count;
    int                    cells_outstanding;

    // knobs owned by the stimulus process
    bit tx_idle_en = 1'b0;      // read only by the stimulus process itself
    bit rx_idle_en = 1'b0;      // read by the output side, so driven by NBA
    int hold_reqs  = 0;         // each bump asks the output side for one long hold-off

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    text_glyph_screen_placer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tgsp_cell_checker i_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .fail_count        (fail_count),
        .cells_outstanding (cells_outstanding)
    );

    // symmetric random value in -half..half
    function automatic int spread(int half);
        return int'($urandom_range(2 * half)) - half;
    endfunction

    // one register set per phase: everyday, rotated, maximum, minimum (cos/sin at +-1.0) or raw random bits
    function automatic cfg_t make_setting(setting_kind_t kind);
        cfg_t c;
        case (kind)
            SET_PLAIN:
            begin
                c.base_x  = 24'(spread(256000));
                c.base_y  = 24'(spread(256000));
                c.zoom_x  = 16'sd4096;
                c.zoom_y  = 16'sd4096;
                c.cos_rot = 16'sd16384;
                c.sin_rot = '0;
                c.pivot_x = '0;
                c.pivot_y = '0;
            end
            SET_ROTATED:
            begin
                c.base_x  = 24'(spread(51200));
                c.base_y  = 24'(spread(51200));
                c.zoom_x  = 16'($urandom_range(16384, 1024));
                c.zoom_y  = 16'($urandom_range(16384, 1024));
                c.cos_rot = 16'(spread(16384));
                c.sin_rot = 16'(spread(16384));
                // half the time anchored at the corner
                c.pivot_x = $urandom_range(1) ? 24'(spread(25600)) : '0;
                c.pivot_y = $urandom_range(1) ? 24'(spread(25600)) : '0;
            end
            SET_TOP:
            begin
                c.base_x  = 24'h7fffff;
                c.base_y  = 24'h7fffff;
                c.zoom_x  = 16'h7fff;
                c.zoom_y  = 16'h7fff;
                c.cos_rot = 16'sd16384;
                c.sin_rot = 16'sd16384;
                c.pivot_x = 24'h7fffff;
                c.pivot_y = 24'h7fffff;
            end
            SET_BOTTOM:
            begin
                c.base_x  = 24'h800000;
                c.base_y  = 24'h800000;
                c.zoom_x  = 16'h8000;
                c.zoom_y  = 16'h8000;
                c.cos_rot = -16'sd16384;
                c.sin_rot = -16'sd16384;
                c.pivot_x = 24'h800000;
                c.pivot_y = 24'h800000;
            end
            default:
            begin
                // anything the fields hold, cos/sin beyond +-1.0 included
                c.base_x  = 24'($urandom);
                c.base_y  = 24'($urandom);
                c.zoom_x  = 16'($urandom);
                c.zoom_y  = 16'($urandom);
                c.cos_rot = 16'($urandom);
                c.sin_rot = 16'($urandom);
                c.pivot_x = 24'($urandom);
                c.pivot_y = 24'($urandom);
            end
        endcase
        return c;
    endfunction

    // write all eight registers back to back; valid stays up across the burst.
    // 16-bit registers get random upper data bits, which the block must ignore.
    task automatic load_regs(input cfg_t c);
        logic [CFG_DATA_W-1:0] vals [8];
        vals[CFG_BASE_X]  = c.base_x;
        vals[CFG_BASE_Y]  = c.base_y;
        vals[CFG_ZOOM_X]  = {8'($urandom), c.zoom_x};
        vals[CFG_ZOOM_Y]  = {8'($urandom), c.zoom_y};
        vals[CFG_COS_ROT] = {8'($urandom), c.cos_rot};
        vals[CFG_SIN_ROT] = {8'($urandom), c.sin_rot};
        vals[CFG_PIVOT_X] = c.pivot_x;
        vals[CFG_PIVOT_Y] = c.pivot_y;
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // offer one character and hold it until taken; s_tvalid stays high afterwards
    // so back-to-back items need no extra assignment in the same step
    task automatic send_char(input logic [7:0] ch, input logic st, input logic er);
        while (tx_idle_en && $urandom_range(99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= {er, st};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // mostly plausible text: printable bytes broken by spaces and newlines,
    // with a sprinkle of arbitrary bytes and stray text starts
    task automatic send_text(input int n);
        int         r;
        logic [7:0] ch;
        logic       st;
        st = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 14)
                ch = NL_CODE;
            else if (r < 30)
                ch = SP_CODE;
            else if (r < 40)
                ch = 8'($urandom);
            else
                ch = 8'($urandom_range(126, 33));
            send_char(ch, st, $urandom_range(99) < 20);
            st = ($urandom_range(99) < 6);
        end
    endtask

    // stop offering, wait until every predicted cell has been seen,
    // then give the pipeline time to empty out of spaces and newlines too
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (cells_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // output side: random stalls, plus one long hold-off on request so the
    // pipeline and queue fill and the input gets stalled
    initial
    begin : rx_side
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = 90;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en)
                m_tready <= ($urandom_range(99) >= 24);
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin : stim
        setting_kind_t plan [8];
        plan = '{SET_PLAIN, SET_TOP, SET_ROTATED, SET_BOTTOM,
                 SET_ROTATED, SET_WILD, SET_PLAIN, SET_WILD};

        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed text on reset register values (unit zoom, no rotation)
        tx_idle_en = 1'b1;
        rx_idle_en <= 1'b1;
        send_char("H",     1'b1, 1'b0);
        send_char("i",     1'b0, 1'b0);
        send_char(SP_CODE, 1'b0, 1'b0);
        send_char(8'h00,   1'b0, 1'b0);   // byte zero is drawn
        send_char(NL_CODE, 1'b0, 1'b0);
        send_char(8'hff,   1'b0, 1'b1);   // top byte, erased
        send_char(8'h01,   1'b0, 1'b0);   // control byte is drawn
        send_char(NL_CODE, 1'b1, 1'b0);   // text start on a newline: clear, then line 1
        send_char("x",     1'b0, 1'b0);
        send_char(SP_CODE, 1'b1, 1'b0);   // text start on a space: clear, then column 1
        send_char("y",     1'b0, 1'b0);
        send_char(SP_CODE, 1'b0, 1'b1);   // erased space still gives nothing
        send_char(8'h7f,   1'b0, 1'b0);
        send_char(8'h0d,   1'b0, 1'b0);
        send_char(8'h80,   1'b0, 1'b0);
        send_char(NL_CODE, 1'b0, 1'b1);
        send_char("z",     1'b1, 1'b1);
        settle();

        // random phases, one register set each
        for (int ph = 0; ph < 8; ph++)
        begin
            load_regs(make_setting(plan[ph]));
            // phase 2 runs flat out on both sides; phase 4 holds the output
            // off for a long stretch while input keeps coming
            tx_idle_en = (ph != 2 && ph != 4);
            rx_idle_en <= (ph != 2);
            if (ph == 4)
                hold_reqs <= hold_reqs + 1;
            send_text(56);
            settle();
        end

        if (fail_count == 0 && cells_outstanding == 0)
            $display("text_glyph_screen_placer regression: pass");
        else
            $display("text_glyph_screen_placer regression: fail");
        $finish;
    end

    // run limit, far beyond the slowest passing run
    initial
    begin : watchdog
        #200000;
        $display("text_glyph_screen_placer regression: fail");
        $finish;
    end

endmodule
